>>> rtl/core/tmn_pkg.sv
// ----------------------------------------------------------------------------
// tmn_pkg: shared types and constants of the timestamp min-max normalizer
// Word formats of both channels, opcodes, status codes and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmn_pkg;

    localparam int OUT_W   = 16;
    localparam int Q_DEPTH = 4;
    localparam int LEVEL_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ZERO_SPAN = 2'd1,
        STAT_RANGE     = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] time_value;
        logic [15:0]        point_index;
        logic [16:0]        point_total;
    } req_word_t;

    typedef struct packed {
        logic [15:0] normalized_time;
        logic [1:0]  status;
    } rsp_word_t;

    // Command part of one queue entry; operands travel beside it.
    typedef struct packed {
        logic    need_div;
        status_t status;
    } q_cmd_t;

endpackage

>>> rtl/core/tmn_ram.sv
// ----------------------------------------------------------------------------
// tmn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tmn_front.sv
// ----------------------------------------------------------------------------
// tmn_front: request decode, sample store and running min/max
// Applies clear and load (a load only while the store is not full) at once; turns a read into one queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmn_front import tmn_pkg::*; #(
    parameter int STORE_DEPTH = 65536,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_word_t            req_word,
    input  logic [LEVEL_W-1:0]   q_level,
    output logic                 q_push,
    output logic [$bits(q_cmd_t)+2*((TIME_WIDTH > 17) ? TIME_WIDTH : 17)-1:0] q_data
);

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W   = (COUNT_W > 16) ? COUNT_W : 16;
    localparam int DW      = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;

    logic                         accept;
    logic                         do_clear;
    logic                         do_load;
    logic                         do_read;
    logic                         full;
    logic                         loaded;
    logic                         out_of_range;
    logic [TIME_WIDTH+31:0]       t_wide;
    logic signed [TIME_WIDTH-1:0] t_val;
    logic [AW+15:0]               idx_wide;

    logic [COUNT_W-1:0]           count_reg, count_next;
    logic signed [TIME_WIDTH-1:0] min_reg, min_next;
    logic signed [TIME_WIDTH-1:0] max_reg, max_next;

    logic                         s1_valid_reg;
    logic                         s1_loaded_reg;
    logic                         s1_range_reg;
    logic [15:0]                  s1_idx_reg;
    logic [16:0]                  s1_total_reg;
    logic [TIME_WIDTH-1:0]        s1_min_reg;
    logic [TIME_WIDTH-1:0]        s1_span_reg;

    logic [TIME_WIDTH-1:0]        ram_rdata;
    logic [TIME_WIDTH-1:0]        diff;
    q_cmd_t                       cmd;
    logic [DW-1:0]                num;
    logic [DW-1:0]                den;

    // Hold off new words while the queue might not take the word in flight.
    assign req_stall = ((LEVEL_W + 1)'(q_level) + (LEVEL_W + 1)'(s1_valid_reg))
                       >= (LEVEL_W + 1)'(Q_DEPTH);

    assign accept   = req_valid && !req_stall;
    assign do_clear = accept && (req_word.opcode == OP_CLEAR);
    assign full     = (count_reg == COUNT_W'(STORE_DEPTH));
    assign do_load  = accept && (req_word.opcode == OP_LOAD) && !full;
    assign do_read  = accept && (req_word.opcode == OP_READ);

    assign t_wide   = {{TIME_WIDTH{req_word.time_value[31]}}, req_word.time_value};
    assign t_val    = t_wide[TIME_WIDTH-1:0];
    assign idx_wide = {{AW{1'b0}}, req_word.point_index};

    assign loaded       = (count_reg != '0);
    assign out_of_range = loaded
        ? (CMP_W'(req_word.point_index) >= CMP_W'(count_reg))
        : ({1'b0, req_word.point_index} >= req_word.point_total);

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (do_clear)
        begin
            count_next = '0;
            min_next   = '0;
            max_next   = '0;
        end
        else if (do_load)
        begin
            count_next = count_reg + 1'b1;
            if (!loaded)
            begin
                min_next = t_val;
                max_next = t_val;
            end
            else
            begin
                if (t_val < min_reg)
                begin
                    min_next = t_val;
                end
                if (t_val > max_reg)
                begin
                    max_next = t_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            s1_valid_reg <= do_read;
            if (do_read)
            begin
                s1_loaded_reg <= loaded;
                s1_range_reg  <= out_of_range;
                s1_idx_reg    <= req_word.point_index;
                s1_total_reg  <= req_word.point_total;
                s1_min_reg    <= min_reg;
                s1_span_reg   <= max_reg - min_reg;
            end
        end
    end

    tmn_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_load),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (t_val),
        .rd_en   (do_read),
        .rd_addr (idx_wide[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Second step of a read: build the queue entry, a division job or a status-only entry.
    assign diff = ram_rdata - s1_min_reg;

    always_comb
    begin
        cmd.need_div = 1'b0;
        cmd.status   = STAT_OK;
        num          = DW'(s1_idx_reg);
        den          = DW'(s1_total_reg);
        if (s1_range_reg)
        begin
            cmd.status = STAT_RANGE;
        end
        else if (!s1_loaded_reg)
        begin
            cmd.need_div = 1'b1;
        end
        else if (s1_span_reg == '0)
        begin
            cmd.status = STAT_ZERO_SPAN;
        end
        else
        begin
            cmd.need_div = 1'b1;
            num          = DW'(diff);
            den          = DW'(s1_span_reg);
        end
    end

    assign q_push = s1_valid_reg;
    assign q_data = {cmd, num, den};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_level < LEVEL_W'(Q_DEPTH)))
        else $error("read pushed into a full queue");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above running maximum");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        do_clear |=> (count_reg == '0))
        else $error("clear did not empty the scan");

endmodule

>>> rtl/core/tmn_queue.sv
// ----------------------------------------------------------------------------
// tmn_queue: short register FIFO between front and back
// Head word is shown combinationally; level counts stored entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= push_data;
            end
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign level    = level_reg;

endmodule

>>> rtl/core/tmn_back.sv
// ----------------------------------------------------------------------------
// tmn_back: fraction divider and response register
// Restoring division, one quotient bit per cycle, into Q0.FRACTION_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmn_back import tmn_pkg::*; #(
    parameter int TIME_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LEVEL_W-1:0] q_level,
    output logic               q_pop,
    input  logic [$bits(q_cmd_t)+2*((TIME_WIDTH > 17) ? TIME_WIDTH : 17)-1:0] q_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp_word
);

    localparam int DW      = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;
    localparam int CMD_W   = $bits(q_cmd_t);
    localparam int ENTRY_W = CMD_W + 2 * DW;
    localparam int CNT_W   = $clog2(FRACTION_BITS);

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                   state_reg, state_next;
    logic [DW-1:0]            rem_reg, rem_next;
    logic [DW-1:0]            den_reg, den_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     sat_reg, sat_next;
    logic                     out_valid_reg, out_valid_next;
    rsp_word_t                out_word_reg, out_word_next;

    q_cmd_t                   pop_cmd;
    logic [DW-1:0]            pop_num;
    logic [DW-1:0]            pop_den;
    logic                     out_free;
    logic [DW-1:0]            gap;
    logic                     take;
    logic [DW-1:0]            rem_step;
    logic [FRACTION_BITS-1:0] quo_step;
    logic [FRACTION_BITS-1:0] quo_final;
    logic [OUT_W+FRACTION_BITS-1:0] quo_wide;

    assign pop_cmd = q_cmd_t'(q_data[ENTRY_W-1 -: CMD_W]);
    assign pop_num = q_data[2*DW-1:DW];
    assign pop_den = q_data[DW-1:0];

    assign out_free = !out_valid_reg || !rsp_stall;

    // One restoring step without forming 2*rem: compare rem against den - rem.
    assign gap       = den_reg - rem_reg;
    assign take      = (rem_reg >= gap);
    assign rem_step  = take ? (rem_reg - gap) : (rem_reg << 1);
    assign quo_step  = {quo_reg[FRACTION_BITS-2:0], take};
    assign quo_final = sat_reg ? {FRACTION_BITS{1'b1}} : quo_step;
    assign quo_wide  = {{OUT_W{1'b0}}, quo_final};

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_word_next  = out_word_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if ((q_level != '0) && out_free)
                begin
                    q_pop = 1'b1;
                    if (pop_cmd.need_div)
                    begin
                        rem_next   = pop_num;
                        den_next   = pop_den;
                        quo_next   = '0;
                        cnt_next   = '0;
                        sat_next   = (pop_num >= pop_den);
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        out_valid_next                = 1'b1;
                        out_word_next.normalized_time = '0;
                        out_word_next.status          = pop_cmd.status;
                    end
                end
            end
            ST_DIVIDE:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (sat_reg || (cnt_reg == CNT_W'(FRACTION_BITS - 1)))
                begin
                    out_valid_next                = 1'b1;
                    out_word_next.normalized_time = quo_wide[OUT_W-1:0];
                    out_word_next.status          = STAT_OK;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            den_reg       <= den_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    a_divide_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> !out_valid_reg)
        else $error("response register busy during division");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (cnt_reg <= CNT_W'(FRACTION_BITS - 1)))
        else $error("division step count overran");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !pop_cmd.need_div) |=> out_valid_reg)
        else $error("status-only entry produced no response");

endmodule

>>> rtl/core/timestamp_minmax_normalizer.sv
// ----------------------------------------------------------------------------
// timestamp_minmax_normalizer: min-max normalization of scan timestamps
// Clear and load words produce no response.
// A read that needs a division passes the store read, the queue and the
// bit-serial divider in the back end; the back end takes the next queued
// job only once the last one has finished. Out-of-range and zero-span reads
// complete one per cycle once queued, while the response is not stalled.
// Reset clears the fill count, min/max, queue and response; the sample store
// is not cleared, the fill count guards every read of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Structure
//   front : decodes each request word. Clear and load update the fill count,
//           running min/max and the sample store in the cycle they are taken.
//           A read fetches its sample from the store (registered read) and, in the
//           next cycle, pushes either a status-only entry or a division job
//           {numerator, denominator} into the queue. The span and minimum are
//           captured at read time, so later loads do not disturb a pending read.
//   queue : four-entry FIFO; the front stalls requests while the queue could
//           not take the read still in flight.
//   back  : pops one entry at a time. Status-only entries go straight to the
//           response register; division jobs run a restoring divider that
//           yields one quotient bit per cycle. numerator >= denominator
//           saturates to all ones without iterating.
// With no samples loaded, a read divides point_index by point_total instead.

module timestamp_minmax_normalizer import tmn_pkg::*; #(
    parameter int STORE_DEPTH   = 65536,
    parameter int TIME_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    // Division operands are wide enough for a span and for point_total.
    localparam int DW      = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;
    localparam int ENTRY_W = $bits(q_cmd_t) + 2 * DW;

    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_head;
    logic [LEVEL_W-1:0] q_level;

    // Decode, store and track min/max; issue reads into the queue.
    tmn_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Decouple the front from the iterating back end.
    tmn_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_head),
        .level     (q_level)
    );

    // Divide and hold the response until the consumer takes it.
    tmn_back #(
        .TIME_WIDTH    (TIME_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_level   (q_level),
        .q_pop     (q_pop),
        .q_data    (q_head),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
